### rtl/assert_macros.svh
// Assertion macros shared by the checker modules of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, expr) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/asn1ts_pkg.sv
// Shared types and constants of the ASN.1 time string parser.
`timescale 1ns / 1ps
`default_nettype none

package asn1ts_pkg;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_LEN  = 2'd1,
		ST_BAD_CHAR = 2'd2,
		ST_BAD_DATE = 2'd3
	} status_t;

	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned FIELD_W = 7;
	localparam int unsigned POS_W   = 5;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_Z    = 8'h5A;

	localparam logic [YEAR_W-1:0]  YEAR_MAX     = 14'd9999;
	localparam logic [YEAR_W-1:0]  YEAR_BASE_19 = 14'd1900;
	localparam logic [YEAR_W-1:0]  YEAR_BASE_20 = 14'd2000;
	localparam logic [YEAR_W-1:0]  UTC_PIVOT    = 14'd50;
	localparam logic [POS_W-1:0]   POS_MAX      = 5'd31;

endpackage

`default_nettype wire

### rtl/asn1_time_string_parser.sv
// Top level: ASN.1 UTCTime / GeneralizedTime content parser.
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+--------------------------------------------
//  char    | char_valid | char_stall | char_byte, four_digit_year, last
//  result  | res_valid  | res_stall  | status, year/month/day/hour/minute/second_out
//
// One character word per cycle unless a stalled result holds the input register.
// Words wait in the input register; a last word's result enters the output register.
// Throughput is set by the single digit-accumulate and date-check path between them.
// Reset clears the position, format, accumulators and error flags; no clearing pass.
// A stalled result holds the output register; the input register still drains
// while the output register is empty or being taken in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module asn1_time_string_parser
	import asn1ts_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               char_valid,
	output logic                    char_stall,
	input  wire logic [7:0]         char_byte,
	input  wire logic               four_digit_year,
	input  wire logic               last,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic [1:0]              status,
	output logic [YEAR_W-1:0]       year_out,
	output logic [FIELD_W-1:0]      month_out,
	output logic [FIELD_W-1:0]      day_out,
	output logic [FIELD_W-1:0]      hour_out,
	output logic [FIELD_W-1:0]      minute_out,
	output logic [FIELD_W-1:0]      second_out
);

	// acc*10 + d, truncated to the field width
	function automatic logic [YEAR_W-1:0] mul10_y(input logic [YEAR_W-1:0] acc,
		input logic [3:0] d);
		logic [YEAR_W-1:0] s;
		s = (acc << 3) + (acc << 1) + YEAR_W'(d);
		return s;
	endfunction

	function automatic logic [FIELD_W-1:0] mul10_f(input logic [FIELD_W-1:0] acc,
		input logic [3:0] d);
		logic [FIELD_W-1:0] s;
		s = (acc << 3) + (acc << 1) + FIELD_W'(d);
		return s;
	endfunction

	// Input register
	logic               valid_s1;
	logic [7:0]         char_s1;
	logic               fmt_s1;
	logic               last_s1;

	// Parse state
	logic [POS_W-1:0]   pos_q;
	logic               fmt_q;
	logic [YEAR_W-1:0]  year_q;
	logic [FIELD_W-1:0] month_q, day_q, hour_q, minute_q, second_q;
	logic               early_err_q, sec_err_q, trail_z_q;
	logic               yz0_q, yz1_q;   // last and previous year digit were zero

	// Next-state values
	logic               fmt_n;
	logic [YEAR_W-1:0]  year_n;
	logic [FIELD_W-1:0] month_n, day_n, hour_n, minute_n, second_n;
	logic               early_err_n, sec_err_n, trail_z_n;
	logic               yz0_n, yz1_n;

	logic               advance;
	logic               accept;
	logic               is_dig;
	logic [3:0]         dig;
	logic [5:0]         idx6, ylen, len6;
	logic [YEAR_W-1:0]  yr;
	logic               leap;
	logic [FIELD_W-1:0] mlen;
	logic               mon_ok;
	logic               date_ok;
	status_t            st;

	logic               res_valid_q;
	logic [1:0]         status_q;
	logic [YEAR_W-1:0]  year_out_q;
	logic [FIELD_W-1:0] month_out_q, day_out_q, hour_out_q, minute_out_q, second_out_q;

	// Handshake
	assign advance    = valid_s1 && (!res_valid_q || !res_stall);
	assign char_stall = valid_s1 && !advance;
	assign accept     = char_valid && !char_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_byte;
			fmt_s1  <= four_digit_year;
			last_s1 <= last;
		end
	end

	// Digit decode and field routing by position
	always_comb begin
		is_dig      = (char_s1 >= CHAR_ZERO) && (char_s1 <= CHAR_NINE);
		dig         = is_dig ? char_s1[3:0] : 4'd0;
		fmt_n       = (pos_q == '0) ? fmt_s1 : fmt_q;
		ylen        = fmt_n ? 6'd4 : 6'd2;
		idx6        = {1'b0, pos_q};
		len6        = idx6 + 6'd1;

		year_n      = year_q;
		month_n     = month_q;
		day_n       = day_q;
		hour_n      = hour_q;
		minute_n    = minute_q;
		second_n    = second_q;
		early_err_n = early_err_q;
		sec_err_n   = sec_err_q;
		trail_z_n   = trail_z_q;
		yz0_n       = yz0_q;
		yz1_n       = yz1_q;

		priority if (idx6 < ylen + 6'd8) begin
			priority if (!is_dig) begin
				early_err_n = 1'b1;
			end else if (idx6 < ylen) begin
				year_n = mul10_y(year_q, dig);
				yz1_n  = yz0_q;
				yz0_n  = (dig == 4'd0);
			end else if (idx6 < ylen + 6'd2) begin
				month_n = mul10_f(month_q, dig);
			end else if (idx6 < ylen + 6'd4) begin
				day_n = mul10_f(day_q, dig);
			end else if (idx6 < ylen + 6'd6) begin
				hour_n = mul10_f(hour_q, dig);
			end else begin
				minute_n = mul10_f(minute_q, dig);
			end
		end else if (idx6 < ylen + 6'd10) begin
			if (!is_dig) begin
				sec_err_n = 1'b1;
			end else begin
				second_n = mul10_f(second_q, dig);
			end
		end else if (idx6 == ylen + 6'd10) begin
			trail_z_n = (char_s1 == CHAR_Z);
		end else begin
			trail_z_n = trail_z_q;
		end
	end

	// Calendar check; leap rule uses binary low bits and the last two year digits
	always_comb begin
		if (fmt_n) begin
			yr = year_n;
		end else if (year_n < UTC_PIVOT) begin
			yr = year_n + YEAR_BASE_20;
		end else begin
			yr = year_n + YEAR_BASE_19;
		end

		// century year (last two digits zero) must be a multiple of 400, i.e. of 16
		leap = (yz0_n && yz1_n) ? (yr[3:0] == 4'd0) : (yr[1:0] == 2'd0);

		mon_ok = 1'b1;
		unique case (month_n)
			7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: mlen = 7'd31;
			7'd4, 7'd6, 7'd9, 7'd11:                    mlen = 7'd30;
			7'd2:                                        mlen = leap ? 7'd29 : 7'd28;
			default: begin
				mlen   = 7'd0;
				mon_ok = 1'b0;
			end
		endcase

		date_ok = mon_ok && (yr <= YEAR_MAX) && (hour_n <= 7'd23) &&
			(minute_n <= 7'd59) && (second_n <= 7'd59) &&
			(day_n >= 7'd1) && (day_n <= mlen);
	end

	// Status in priority order
	always_comb begin
		priority if (len6 < ylen + 6'd8) begin
			st = ST_BAD_LEN;
		end else if (early_err_n) begin
			st = ST_BAD_CHAR;
		end else if (len6 < ylen + 6'd10) begin
			st = ST_BAD_LEN;
		end else if (sec_err_n) begin
			st = ST_BAD_CHAR;
		end else if ((len6 == ylen + 6'd10) || ((len6 == ylen + 6'd11) && trail_z_n)) begin
			st = date_ok ? ST_OK : ST_BAD_DATE;
		end else begin
			st = ST_BAD_LEN;
		end
	end

	// Parse state: updates per word, clears after the last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			fmt_q       <= 1'b0;
			year_q      <= '0;
			month_q     <= '0;
			day_q       <= '0;
			hour_q      <= '0;
			minute_q    <= '0;
			second_q    <= '0;
			early_err_q <= 1'b0;
			sec_err_q   <= 1'b0;
			trail_z_q   <= 1'b0;
			yz0_q       <= 1'b0;
			yz1_q       <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				pos_q       <= '0;
				fmt_q       <= 1'b0;
				year_q      <= '0;
				month_q     <= '0;
				day_q       <= '0;
				hour_q      <= '0;
				minute_q    <= '0;
				second_q    <= '0;
				early_err_q <= 1'b0;
				sec_err_q   <= 1'b0;
				trail_z_q   <= 1'b0;
				yz0_q       <= 1'b0;
				yz1_q       <= 1'b0;
			end else begin
				pos_q       <= (pos_q == POS_MAX) ? pos_q : pos_q + 5'd1;
				fmt_q       <= fmt_n;
				year_q      <= year_n;
				month_q     <= month_n;
				day_q       <= day_n;
				hour_q      <= hour_n;
				minute_q    <= minute_n;
				second_q    <= second_n;
				early_err_q <= early_err_n;
				sec_err_q   <= sec_err_n;
				trail_z_q   <= trail_z_n;
				yz0_q       <= yz0_n;
				yz1_q       <= yz1_n;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= last_s1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			status_q <= st;
			if (st == ST_BAD_LEN || st == ST_BAD_CHAR) begin
				year_out_q   <= '0;
				month_out_q  <= '0;
				day_out_q    <= '0;
				hour_out_q   <= '0;
				minute_out_q <= '0;
				second_out_q <= '0;
			end else begin
				year_out_q   <= yr;
				month_out_q  <= month_n;
				day_out_q    <= day_n;
				hour_out_q   <= hour_n;
				minute_out_q <= minute_n;
				second_out_q <= second_n;
			end
		end
	end

	assign res_valid  = res_valid_q;
	assign status     = status_q;
	assign year_out   = year_out_q;
	assign month_out  = month_out_q;
	assign day_out    = day_out_q;
	assign hour_out   = hour_out_q;
	assign minute_out = minute_out_q;
	assign second_out = second_out_q;

endmodule

`default_nettype wire

### rtl/asn1ts_checker.sv
// Port-level checker for the ASN.1 time string parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module asn1ts_checker
	import asn1ts_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               res_valid,
	input  wire logic               res_stall,
	input  wire logic [1:0]         status,
	input  wire logic [YEAR_W-1:0]  year_out,
	input  wire logic [FIELD_W-1:0] month_out,
	input  wire logic [FIELD_W-1:0] day_out,
	input  wire logic [FIELD_W-1:0] hour_out,
	input  wire logic [FIELD_W-1:0] minute_out,
	input  wire logic [FIELD_W-1:0] second_out
);

	logic err_word;
	logic ok_word;
	logic zero_fields;
	logic in_range;

	assign err_word    = res_valid && (status == ST_BAD_LEN || status == ST_BAD_CHAR);
	assign ok_word     = res_valid && (status == ST_OK);
	assign zero_fields = (year_out == '0) && (month_out == '0) && (day_out == '0) &&
		(hour_out == '0) && (minute_out == '0) && (second_out == '0);
	assign in_range    = (year_out <= YEAR_MAX) && (month_out >= 7'd1) &&
		(month_out <= 7'd12) && (day_out >= 7'd1) && (day_out <= 7'd31) &&
		(hour_out <= 7'd23) && (minute_out <= 7'd59) && (second_out <= 7'd59);

	// stalled result word holds
	`ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(status) && $stable(year_out) && $stable(day_out))

	// length and character errors carry no date
	`ASSERT_IMPLIES(a_err_zero, clk, arst_n, err_word, zero_fields)

	// a good date is in calendar range
	`ASSERT_IMPLIES(a_ok_range, clk, arst_n, ok_word, in_range)

	// February never passes beyond the 29th
	`ASSERT_IMPLIES(a_ok_feb, clk, arst_n, ok_word && (month_out == 7'd2), day_out <= 7'd29)

endmodule

bind asn1_time_string_parser asn1ts_checker u_asn1ts_checker (.*);

`default_nettype wire

### bench/testbench.sv
// Self-checking testbench for the ASN.1 time string parser.
`timescale 1ns / 1ps

module testbench;
	import asn1ts_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_CHARS    = 260;

	// One decoded time as it leaves the result channel
	typedef struct packed {
		status_t            stat;
		logic [YEAR_W-1:0]  year;
		logic [FIELD_W-1:0] month;
		logic [FIELD_W-1:0] mday;
		logic [FIELD_W-1:0] hour;
		logic [FIELD_W-1:0] minute;
		logic [FIELD_W-1:0] sec;
	} time_result_t;

	// One character word waiting to be sent, with an optional hand-written result
	typedef struct packed {
		logic [7:0]   ch;
		logic         gen_fmt;
		logic         is_last;
		logic         has_typed;
		time_result_t typed;
	} char_word_t;

	typedef struct {
		string        text;
		bit           gen4;
		bit           typed;
		time_result_t res;
	} dir_row_t;

	localparam time_result_t NO_TYPED = '{ST_OK, 14'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0};
	localparam time_result_t LEN_ERR  = '{ST_BAD_LEN, 14'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0};
	localparam time_result_t CHAR_ERR = '{ST_BAD_CHAR, 14'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0};

	// Directed strings: format flag on the first character, result typed where obvious
	dir_row_t dir_rows [25] = '{
		'{"0",                   1'b0, 1'b1, LEN_ERR},
		'{"000101000000",        1'b0, 1'b1,
			'{ST_OK, 14'd2000, 7'd1, 7'd1, 7'd0, 7'd0, 7'd0}},
		'{"991231235959Z",       1'b0, 1'b1,
			'{ST_OK, 14'd1999, 7'd12, 7'd31, 7'd23, 7'd59, 7'd59}},
		'{"491231235959Z",       1'b0, 1'b0, NO_TYPED},
		'{"500101000000Z",       1'b0, 1'b0, NO_TYPED},
		'{"99991231235959Z",     1'b1, 1'b1,
			'{ST_OK, 14'd9999, 7'd12, 7'd31, 7'd23, 7'd59, 7'd59}},
		'{"00000101000000",      1'b1, 1'b0, NO_TYPED},
		'{"9A123123",            1'b0, 1'b1, LEN_ERR},
		'{"99A231235959",        1'b0, 1'b1, CHAR_ERR},
		'{"99A2312359",          1'b0, 1'b1, CHAR_ERR},
		'{"9912312359",          1'b0, 1'b1, LEN_ERR},
		'{"99123123595/",        1'b0, 1'b1, CHAR_ERR},
		'{"9912312359:9Z",       1'b0, 1'b1, CHAR_ERR},
		'{"991231235959z",       1'b0, 1'b1, LEN_ERR},
		'{"991231235959ZZ",      1'b0, 1'b1, LEN_ERR},
		'{"12345678901234567890123456789012345", 1'b1, 1'b1, LEN_ERR},
		'{"991331235959Z",       1'b0, 1'b1,
			'{ST_BAD_DATE, 14'd1999, 7'd13, 7'd31, 7'd23, 7'd59, 7'd59}},
		'{"991231245959",        1'b0, 1'b0, NO_TYPED},
		'{"20000229000000Z",     1'b1, 1'b0, NO_TYPED},
		'{"21000229000000Z",     1'b1, 1'b0, NO_TYPED},
		'{"240229000000",        1'b0, 1'b0, NO_TYPED},
		'{"230229000000Z",       1'b0, 1'b0, NO_TYPED},
		'{"990431000000",        1'b0, 1'b0, NO_TYPED},
		'{"990000000000",        1'b0, 1'b0, NO_TYPED},
		'{"99\377231235959",     1'b0, 1'b1, CHAR_ERR}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                char_valid = 1'b0;
	logic                char_stall;
	logic [7:0]          char_byte = 8'd0;
	logic                four_digit_year = 1'b0;
	logic                last = 1'b0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	logic [1:0]          status;
	logic [YEAR_W-1:0]   year_out;
	logic [FIELD_W-1:0]  month_out;
	logic [FIELD_W-1:0]  day_out;
	logic [FIELD_W-1:0]  hour_out;
	logic [FIELD_W-1:0]  minute_out;
	logic [FIELD_W-1:0]  second_out;

	char_word_t   send_q [$];
	time_result_t expected_times [$];
	int           mismatches = 0;
	int           snd_idle_pct = 0;
	int           rcv_stall_pct = 0;
	int           quiet_cycles = 0;

	// Parser state as the predictor tracks it
	logic [POS_W-1:0]   pos_cnt = '0;
	logic               fmt_lat = 1'b0;
	logic [YEAR_W-1:0]  yr_acc = '0;
	logic [FIELD_W-1:0] mon_acc = '0;
	logic [FIELD_W-1:0] mday_acc = '0;
	logic [FIELD_W-1:0] hr_acc = '0;
	logic [FIELD_W-1:0] min_acc = '0;
	logic [FIELD_W-1:0] sec_acc = '0;
	logic               early_bad = 1'b0;
	logic               sec_bad = 1'b0;
	logic [7:0]         trail_ch = 8'd0;

	asn1_time_string_parser DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.char_valid     (char_valid),
		.char_stall     (char_stall),
		.char_byte      (char_byte),
		.four_digit_year(four_digit_year),
		.last           (last),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.status         (status),
		.year_out       (year_out),
		.month_out      (month_out),
		.day_out        (day_out),
		.hour_out       (hour_out),
		.minute_out     (minute_out),
		.second_out     (second_out)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Range and Gregorian calendar check of a decoded time
	function automatic bit calendar_ok(int y, int mo, int d, int h, int mi, int s);
		int  mlen;
		bit  leap;
		leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		if (y > YEAR_MAX || h > 23 || mi > 59 || s > 59)
			return 1'b0;
		case (mo)
			1, 3, 5, 7, 8, 10, 12: mlen = 31;
			4, 6, 9, 11:           mlen = 30;
			2:                     mlen = leap ? 29 : 28;
			default:               return 1'b0;
		endcase
		return d >= 1 && d <= mlen;
	endfunction

	// Advance the parser state by one character; returns 1 when a time comes out
	function automatic bit parse_time_char(input logic [7:0] ch, input logic fmt_in,
			input logic is_last, output time_result_t res);
		logic [POS_W-1:0]  idx;
		logic [5:0]        ylen;
		logic [5:0]        len;
		logic              is_dig;
		logic [3:0]        dig;
		logic [YEAR_W-1:0] yr;
		status_t           st;
		res = '0;
		idx = pos_cnt;
		if (idx == 0)
			fmt_lat = fmt_in;
		ylen = fmt_lat ? 6'd4 : 6'd2;
		is_dig = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
		dig = is_dig ? 4'(ch - CHAR_ZERO) : 4'd0;

		// route the digit by position
		if (idx < ylen + 6'd8) begin
			if (!is_dig)
				early_bad = 1'b1;
			else if (idx < ylen)
				yr_acc = yr_acc * 14'd10 + dig;
			else if (idx < ylen + 6'd2)
				mon_acc = mon_acc * 7'd10 + dig;
			else if (idx < ylen + 6'd4)
				mday_acc = mday_acc * 7'd10 + dig;
			else if (idx < ylen + 6'd6)
				hr_acc = hr_acc * 7'd10 + dig;
			else
				min_acc = min_acc * 7'd10 + dig;
		end else if (idx < ylen + 6'd10) begin
			if (!is_dig)
				sec_bad = 1'b1;
			else
				sec_acc = sec_acc * 7'd10 + dig;
		end else if (idx == ylen + 6'd10) begin
			trail_ch = ch;
		end
		if (idx != POS_MAX)
			pos_cnt = idx + 1'b1;
		if (!is_last)
			return 1'b0;

		// two-digit years pivot at 50
		len = 6'(idx) + 6'd1;
		if (fmt_lat)
			yr = yr_acc;
		else
			yr = yr_acc + ((yr_acc < UTC_PIVOT) ? YEAR_BASE_20 : YEAR_BASE_19);

		// first failing check wins
		if (len < ylen + 6'd8)
			st = ST_BAD_LEN;
		else if (early_bad)
			st = ST_BAD_CHAR;
		else if (len < ylen + 6'd10)
			st = ST_BAD_LEN;
		else if (sec_bad)
			st = ST_BAD_CHAR;
		else if (len == ylen + 6'd10 || (len == ylen + 6'd11 && trail_ch == CHAR_Z))
			st = calendar_ok(yr, mon_acc, mday_acc, hr_acc, min_acc, sec_acc) ?
				ST_OK : ST_BAD_DATE;
		else
			st = ST_BAD_LEN;

		res.stat = st;
		if (st == ST_OK || st == ST_BAD_DATE) begin
			res.year   = yr;
			res.month  = mon_acc;
			res.mday   = mday_acc;
			res.hour   = hr_acc;
			res.minute = min_acc;
			res.sec    = sec_acc;
		end

		// the string is done, start over
		pos_cnt  = '0;
		fmt_lat  = 1'b0;
		yr_acc   = '0;
		mon_acc  = '0;
		mday_acc = '0;
		hr_acc   = '0;
		min_acc  = '0;
		sec_acc  = '0;
		early_bad = 1'b0;
		sec_bad  = 1'b0;
		trail_ch = 8'd0;
		return 1'b1;
	endfunction

	task automatic queue_word(input logic [7:0] ch, input logic gen4, input logic lst,
			input logic typed, input time_result_t res);
		char_word_t w;
		w.ch        = ch;
		w.gen_fmt   = gen4;
		w.is_last   = lst;
		w.has_typed = typed;
		w.typed     = res;
		send_q.push_back(w);
	endtask

	task automatic append_digits(ref logic [7:0] txt [$], input int v, input int ndig);
		int div;
		div = 1;
		repeat (ndig - 1) div *= 10;
		repeat (ndig) begin
			txt.push_back(CHAR_ZERO + 8'((v / div) % 10));
			div /= 10;
		end
	endtask

	// Mostly well-formed times with random content; some corrupted, cut, lengthened or pure noise
	task automatic queue_random_string(output int n_chars);
		logic [7:0] txt [$];
		logic       gen4;
		int         kind, yv, mv, dv, hv, nv, sv, tail, k;
		gen4 = 1'($urandom_range(0, 1));
		kind = $urandom_range(0, 99);
		if (kind < 85) begin
			yv = gen4 ? $urandom_range(0, 9999) : $urandom_range(0, 99);
			if (gen4 && $urandom_range(0, 3) == 0)
				yv = yv / 100 * 100;
			mv = $urandom_range(1, 12);
			dv = $urandom_range(1, 31);
			if ($urandom_range(0, 6) == 0) begin
				mv = 2;
				dv = $urandom_range(28, 30);
			end
			hv = $urandom_range(0, 23);
			nv = $urandom_range(0, 59);
			sv = $urandom_range(0, 59);
			// out-of-range fields now and then
			if ($urandom_range(0, 11) == 0) mv = $urandom_range(0, 99);
			if ($urandom_range(0, 11) == 0) dv = $urandom_range(0, 99);
			if ($urandom_range(0, 11) == 0) hv = $urandom_range(0, 99);
			if ($urandom_range(0, 11) == 0) nv = $urandom_range(0, 99);
			if ($urandom_range(0, 11) == 0) sv = $urandom_range(0, 99);
			append_digits(txt, yv, gen4 ? 4 : 2);
			append_digits(txt, mv, 2);
			append_digits(txt, dv, 2);
			append_digits(txt, hv, 2);
			append_digits(txt, nv, 2);
			append_digits(txt, sv, 2);
			tail = $urandom_range(0, 9);
			if (tail < 5)
				txt.push_back(CHAR_Z);
			else if (tail == 5)
				txt.push_back(8'($urandom_range(0, 255)));
			if (kind >= 70 && kind < 78)
				txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
			if (kind >= 78) begin
				if ($urandom_range(0, 1))
					repeat ($urandom_range(1, txt.size() - 1)) void'(txt.pop_back());
				else
					repeat ($urandom_range(1, 20))
						txt.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
			end
		end else begin
			repeat ($urandom_range(1, 40))
				txt.push_back($urandom_range(0, 1) ? CHAR_ZERO + 8'($urandom_range(0, 9)) :
					8'($urandom_range(0, 255)));
		end
		for (k = 0; k < txt.size(); k++)
			queue_word(txt[k], (k == 0) ? gen4 : 1'($urandom_range(0, 1)),
				k == txt.size() - 1, 1'b0, NO_TYPED);
		n_chars = txt.size();
	endtask

	task automatic check_field(input string fname, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
			mismatches++;
		end
	endtask

	// Character sender: predicts on each accepted word, holds payload while stalled
	always @(posedge clk) begin : char_sender
		char_word_t   w;
		time_result_t pred;
		if (!arst_n) begin
			char_valid <= 1'b0;
		end else begin
			if (char_valid && !char_stall) begin
				w = send_q.pop_front();
				if (parse_time_char(char_byte, four_digit_year, last, pred))
					expected_times.push_back(w.has_typed ? w.typed : pred);
			end
			if (char_valid && char_stall) begin
				// hold
			end else if (send_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
				char_valid      <= 1'b1;
				char_byte       <= send_q[0].ch;
				four_digit_year <= send_q[0].gen_fmt;
				last            <= send_q[0].is_last;
			end else begin
				char_valid <= 1'b0;
			end
		end
	end

	// Result receiver stall
	always @(posedge clk) begin
		if (!arst_n)
			res_stall <= 1'b0;
		else
			res_stall <= $urandom_range(0, 99) < rcv_stall_pct;
	end

	// Result checker
	always @(posedge clk) begin : result_checker
		time_result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_times.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual status %0d year %0d",
					$time, status, year_out);
				mismatches++;
			end else begin
				want = expected_times.pop_front();
				check_field("status", want.stat, status);
				check_field("year", want.year, year_out);
				check_field("month", want.month, month_out);
				check_field("day", want.mday, day_out);
				check_field("hour", want.hour, hour_out);
				check_field("minute", want.minute, minute_out);
				check_field("second", want.sec, second_out);
			end
		end
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((char_valid && !char_stall) || (res_valid && !res_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin : main_sequence
		int phase, queued, n, r, i;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed strings
		for (r = 0; r < $size(dir_rows); r++)
			for (i = 0; i < dir_rows[r].text.len(); i++)
				queue_word(dir_rows[r].text[i],
					(i == 0) ? dir_rows[r].gen4 : 1'($urandom_range(0, 1)),
					i == dir_rows[r].text.len() - 1,
					dir_rows[r].typed && i == dir_rows[r].text.len() - 1, dir_rows[r].res);

		// random strings under each idling mix
		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				1: begin snd_idle_pct = 52; rcv_stall_pct = 0; end
				2: begin snd_idle_pct = 0; rcv_stall_pct = 52; end
				3: begin snd_idle_pct = 29; rcv_stall_pct = 29; end
				default: begin snd_idle_pct = 0; rcv_stall_pct = 0; end
			endcase
			queued = 0;
			while (queued < PHASE_CHARS) begin
				queue_random_string(n);
				queued += n;
			end
			while (send_q.size() != 0) @(posedge clk);
		end

		while (send_q.size() != 0 || expected_times.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
